/* design/lmd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lmd_pkg;

  localparam int LOOKAHEAD_MAX = 16;
  localparam int SAMPLE_WIDTH  = 16;
  localparam int POS_WIDTH     = 16;
  localparam int LA_WIDTH      = 5;
  localparam int DELTA_WIDTH   = 16;
  localparam int DATA_WIDTH    = 32;
  localparam int ADDR_WIDTH    = 3;
  localparam int REG_IDX_WIDTH = ADDR_WIDTH - 2;

  localparam int IDX_WIDTH   = $clog2(LOOKAHEAD_MAX);
  localparam int FILL_WIDTH  = $clog2(LOOKAHEAD_MAX + 1);
  localparam int TREE_LEAVES = 1 << IDX_WIDTH;
  localparam int SUM_WIDTH   =
    ((SAMPLE_WIDTH > DELTA_WIDTH) ? SAMPLE_WIDTH : DELTA_WIDTH) + 1;

  localparam logic [REG_IDX_WIDTH-1:0] REG_LOOKAHEAD = 1'b0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_DELTA     = 1'b1;

  localparam logic [LA_WIDTH-1:0]    LOOKAHEAD_RESET = 5'd4;
  localparam logic [DELTA_WIDTH-1:0] DELTA_RESET     = 16'd7;

  typedef enum logic [1:0] {
    MODE_EMPTY    = 2'd0,
    MODE_VALID    = 2'd1,
    MODE_DISABLED = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_JUDGE = 3'b100
  } state_t;

  typedef struct packed {
    logic [LA_WIDTH-1:0]    lookahead;
    logic [DELTA_WIDTH-1:0] delta;
  } cfg_t;

  typedef struct packed {
    logic shift;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic emit;
  } status_t;

endpackage

`default_nettype wire

/* design/lmd_intf.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lmd_in_if;
  logic                              valid;
  logic                              ready;
  logic [lmd_pkg::SAMPLE_WIDTH-1:0]  intensity;
  logic [lmd_pkg::POS_WIDTH-1:0]     position;
  logic                              last;

  modport source (output valid, intensity, position, last, input ready);
  modport sink   (input valid, intensity, position, last, output ready);
endinterface

interface lmd_out_if;
  logic                           valid;
  logic                           ready;
  logic [lmd_pkg::POS_WIDTH-1:0]  min_position;
  logic                           found;
  logic                           stream_end;

  modport source (output valid, min_position, found, stream_end, input ready);
  modport sink   (input valid, min_position, found, stream_end, output ready);
endinterface

`default_nettype wire

/* design/lmd_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module lmd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lmd_pkg::ADDR_WIDTH-1:0]   paddr,
  input  wire logic [lmd_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic      [lmd_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                                  pready,
  output lmd_pkg::cfg_t                         cfg
);

  logic [lmd_pkg::LA_WIDTH-1:0]      lookahead_r, lookahead_nxt;
  logic [lmd_pkg::DELTA_WIDTH-1:0]   delta_r, delta_nxt;
  logic [lmd_pkg::REG_IDX_WIDTH-1:0] reg_idx;
  logic                              wr_en;

  assign reg_idx = paddr[lmd_pkg::ADDR_WIDTH-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    lookahead_nxt = lookahead_r;
    delta_nxt     = delta_r;
    if (wr_en) begin
      case (reg_idx)
        lmd_pkg::REG_LOOKAHEAD: lookahead_nxt = pwdata[lmd_pkg::LA_WIDTH-1:0];
        lmd_pkg::REG_DELTA:     delta_nxt     = pwdata[lmd_pkg::DELTA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lmd_pkg::REG_LOOKAHEAD: prdata = lmd_pkg::DATA_WIDTH'(lookahead_r);
      lmd_pkg::REG_DELTA:     prdata = lmd_pkg::DATA_WIDTH'(delta_r);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookahead_r <= lmd_pkg::LOOKAHEAD_RESET;
      delta_r     <= lmd_pkg::DELTA_RESET;
    end else begin
      lookahead_r <= lookahead_nxt;
      delta_r     <= delta_nxt;
    end
  end

  assign cfg.lookahead = lookahead_r;
  assign cfg.delta     = delta_r;

endmodule

`default_nettype wire

/* design/lmd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lmd_ctrl (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output lmd_pkg::cmd_t  cmd,
  input  wire lmd_pkg::status_t status
);

  lmd_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            stall;

  assign stall = status.emit && out_valid_r && !out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      lmd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.shift = 1'b1;
          state_nxt = lmd_pkg::ST_SCAN;
        end
      end
      lmd_pkg::ST_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = lmd_pkg::ST_JUDGE;
      end
      lmd_pkg::ST_JUDGE: begin
        if (!stall) begin
          cmd.commit = 1'b1;
          state_nxt  = lmd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lmd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.commit && status.emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* design/lmd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module lmd_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire lmd_pkg::cmd_t                      cmd,
  input  wire lmd_pkg::cfg_t                      cfg,
  input  wire logic [lmd_pkg::SAMPLE_WIDTH-1:0]   in_intensity,
  input  wire logic [lmd_pkg::POS_WIDTH-1:0]      in_position,
  input  wire logic                               in_last,
  output lmd_pkg::status_t                        status,
  output logic      [lmd_pkg::POS_WIDTH-1:0]      out_min_position,
  output logic                                    out_found,
  output logic                                    out_stream_end
);

  localparam int SW = lmd_pkg::SAMPLE_WIDTH;
  localparam int PW = lmd_pkg::POS_WIDTH;
  localparam int LM = lmd_pkg::LOOKAHEAD_MAX;
  localparam int TL = lmd_pkg::TREE_LEAVES;
  localparam int UW = lmd_pkg::SUM_WIDTH;
  localparam logic [SW-1:0] SAMPLE_ONES = '1;

  logic [SW-1:0] win_val_r [LM];
  logic [PW-1:0] win_pos_r [LM];
  logic [lmd_pkg::FILL_WIDTH-1:0] fill_r, fill_nxt;
  logic          last_r;

  logic [lmd_pkg::FILL_WIDTH-1:0] len;
  logic [lmd_pkg::IDX_WIDTH-1:0]  judge_idx;
  logic [SW-1:0] max_node [2*TL-1];
  logic [SW-1:0] min_node [2*TL-1];

  logic [SW-1:0] v_r, big_r, small_r;
  logic [PW-1:0] p_r;
  logic          judge_r;

  logic [SW-1:0]   run_max_r, run_min_r, new_max, new_min;
  logic [PW-1:0]   max_pos_r, min_pos_r, new_max_pos, new_min_pos;
  lmd_pkg::mode_t  max_mode_r, min_mode_r, max_mode_nxt, min_mode_nxt;
  lmd_pkg::mode_t  max_mode_u, min_mode_u, max_mode_a, min_mode_a;
  logic            event_r, event_nxt, event_a;
  logic            max_load, min_load, max_conf, min_conf, found;
  logic [UW-1:0]   v_plus_delta, min_plus_delta;

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win_val_r[0] <= in_intensity;
      win_pos_r[0] <= in_position;
      for (int i = 1; i < LM; i++) begin
        win_val_r[i] <= win_val_r[i-1];
        win_pos_r[i] <= win_pos_r[i-1];
      end
      last_r <= in_last;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.shift && int'(fill_r) < LM) fill_nxt = fill_r + 1'b1;
    if (cmd.commit && last_r) fill_nxt = '0;
  end

  // clamp the window length to 1..LOOKAHEAD_MAX
  always_comb begin
    if (cfg.lookahead == '0) begin
      len = lmd_pkg::FILL_WIDTH'(1);
    end else if (int'(cfg.lookahead) > LM) begin
      len = lmd_pkg::FILL_WIDTH'(LM);
    end else begin
      len = lmd_pkg::FILL_WIDTH'(cfg.lookahead);
    end
    judge_idx = lmd_pkg::IDX_WIDTH'(len - 1'b1);
  end

  always_comb begin
    for (int i = 0; i < TL; i++) begin
      if (i < LM && i < int'(len)) begin
        max_node[TL-1+i] = win_val_r[i];
        min_node[TL-1+i] = win_val_r[i];
      end else begin
        max_node[TL-1+i] = '0;
        min_node[TL-1+i] = SAMPLE_ONES;
      end
    end
    for (int k = TL - 2; k >= 0; k--) begin
      max_node[k] = (max_node[2*k+1] > max_node[2*k+2]) ? max_node[2*k+1] : max_node[2*k+2];
      min_node[k] = (min_node[2*k+1] < min_node[2*k+2]) ? min_node[2*k+1] : min_node[2*k+2];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      v_r     <= win_val_r[judge_idx];
      p_r     <= win_pos_r[judge_idx];
      big_r   <= max_node[0];
      small_r <= min_node[0];
      judge_r <= (fill_r >= len);
    end
  end

  always_comb begin
    max_load = judge_r && ((max_mode_r == lmd_pkg::MODE_EMPTY) ||
               (max_mode_r == lmd_pkg::MODE_VALID && v_r > run_max_r));
    min_load = judge_r && ((min_mode_r == lmd_pkg::MODE_EMPTY) ||
               (min_mode_r == lmd_pkg::MODE_VALID && v_r < run_min_r));
    new_max     = max_load ? v_r : run_max_r;
    new_max_pos = max_load ? p_r : max_pos_r;
    new_min     = min_load ? v_r : run_min_r;
    new_min_pos = min_load ? p_r : min_pos_r;
    max_mode_u  = max_load ? lmd_pkg::MODE_VALID : max_mode_r;
    min_mode_u  = min_load ? lmd_pkg::MODE_VALID : min_mode_r;

    v_plus_delta   = UW'(v_r) + UW'(cfg.delta);
    min_plus_delta = UW'(new_min) + UW'(cfg.delta);

    max_conf = judge_r && (max_mode_u == lmd_pkg::MODE_VALID) &&
               (v_plus_delta < UW'(new_max)) && (big_r < new_max);
    max_mode_a = max_conf ? lmd_pkg::MODE_DISABLED : max_mode_u;
    min_mode_a = max_conf ? lmd_pkg::MODE_EMPTY : min_mode_u;
    event_a    = event_r || max_conf;

    min_conf = judge_r && (min_mode_a == lmd_pkg::MODE_VALID) &&
               (UW'(v_r) > min_plus_delta) && (small_r > new_min);
    found    = min_conf && event_a;

    max_mode_nxt = min_conf ? lmd_pkg::MODE_EMPTY : max_mode_a;
    min_mode_nxt = min_conf ? lmd_pkg::MODE_DISABLED : min_mode_a;
    event_nxt    = event_a || min_conf;
    if (last_r) begin
      max_mode_nxt = lmd_pkg::MODE_EMPTY;
      min_mode_nxt = lmd_pkg::MODE_EMPTY;
      event_nxt    = 1'b0;
    end
  end

  assign status.emit = found || last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      max_mode_r <= lmd_pkg::MODE_EMPTY;
      min_mode_r <= lmd_pkg::MODE_EMPTY;
      event_r    <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (cmd.commit) begin
        max_mode_r <= max_mode_nxt;
        min_mode_r <= min_mode_nxt;
        event_r    <= event_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      run_max_r <= new_max;
      max_pos_r <= new_max_pos;
      run_min_r <= new_min;
      min_pos_r <= new_min_pos;
      if (status.emit) begin
        out_min_position <= found ? new_min_pos : '0;
        out_found        <= found;
        out_stream_end   <= last_r;
      end
    end
  end

endmodule

`default_nettype wire

/* design/lookahead_minimum_detector.sv */
`timescale 1ns / 1ps
`default_nettype none
// Local minimum detector with delta threshold and lookahead window.
// in_if: one sample per transfer (intensity, position, last). A sample is
//   judged once lookahead-1 further samples have arrived, so a minimum is
//   reported lookahead-1 samples or more after the sample that holds it.
// out_if: one transfer per input that confirms a reportable minimum
//   (found=1, min_position) or that carries last (stream_end=1); no
//   transfer otherwise. The input marked last clears the stream state.
// APB port: register 0 lookahead (0..31, used clamped to 1..16) at 0x0, register 1 delta at 0x4.
//   Write only while no sample is in flight.
// Sequencing: an accepted sample passes shift, window scan and judge;
//   the controller sequences these one sample at a time, so the block takes
//   no new sample until the last one is judged. The judge step writes the
//   result into the output register and may stall (see below).
// Stall: the output register holds its result until taken; the next sample
//   is accepted meanwhile, and its judge step holds if it has a result and
//   the output register is still full.
// Reset: rst_n (synchronous) restores lookahead 4, delta 7 and an empty
//   stream; the block is ready for a sample as soon as reset is released.
module lookahead_minimum_detector (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lmd_in_if.sink                               in_if,
  lmd_out_if.source                            out_if,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lmd_pkg::ADDR_WIDTH-1:0]  paddr,
  input  wire logic [lmd_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic      [lmd_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                                 pready
);

  lmd_pkg::cfg_t    cfg;
  lmd_pkg::cmd_t    cmd;
  lmd_pkg::status_t status;

  lmd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .status    (status)
  );

  lmd_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg              (cfg),
    .in_intensity     (in_if.intensity),
    .in_position      (in_if.position),
    .in_last          (in_if.last),
    .status           (status),
    .out_min_position (out_if.min_position),
    .out_found        (out_if.found),
    .out_stream_end   (out_if.stream_end)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input taken while previous sample in flight");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.found) |-> out_if.stream_end)
    else $error("result without minimum or stream end");

  a_empty_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.found) |-> (out_if.min_position == '0))
    else $error("position set on result without minimum");

endmodule

`default_nettype wire
